// File: rtl/core/mesi_coherence_directory_assert.svh
// Assertion helpers for the coherence directory.
`ifndef MESI_COHERENCE_DIRECTORY_ASSERT_SVH
`define MESI_COHERENCE_DIRECTORY_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define MCD_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define MCD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/mcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcd_pkg;

    localparam int DEF_HART_COUNT = 8;
    localparam int DEF_LINE_COUNT = 1024;
    localparam int DEF_SINK_BITS  = 4;

    // Request codes as they arrive on the input tuser.
    typedef enum logic [2:0] {
        ACT_ACQ_BLOCK  = 3'd0,
        ACT_ACQ_PERM   = 3'd1,
        ACT_RELEASE    = 3'd2,
        ACT_RELEASE_D  = 3'd3,
        ACT_MARK_MOD   = 3'd4,
        ACT_GRANT_ACK  = 3'd5,
        ACT_INV_OTHERS = 3'd6,
        ACT_INV_ALL    = 3'd7
    } act_t;

    // Result kinds as they leave on the output tuser.
    typedef enum logic [1:0] {
        KIND_PROBE      = 2'd0,
        KIND_GRANT      = 2'd1,
        KIND_GRANT_DATA = 2'd2,
        KIND_REL_ACK    = 2'd3
    } kind_t;

    localparam logic [1:0] CAP_T = 2'd0;
    localparam logic [1:0] CAP_B = 2'd1;
    localparam logic [1:0] CAP_N = 2'd2;

    localparam logic [1:0] LS_I = 2'd0;
    localparam logic [1:0] LS_S = 2'd1;
    localparam logic [1:0] LS_E = 2'd2;
    localparam logic [1:0] LS_M = 2'd3;

    // Classified request held in the queue between front and back.
    typedef struct packed {
        act_t       act;
        logic [2:0] hart;
        logic       trunk;
        logic [7:0] src;
        logic [3:0] size;
        logic       keeps;
        logic [3:0] ack;
    } req_t;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_PROBE,
        BS_SINK,
        BS_REPLY
    } bstate_t;

    // Status from the back end.
    typedef struct packed {
        logic clearing;
        logic sink0_pending;
    } back_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/mcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/mcd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mcd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = slot_reg[rptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage slots.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/mcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mcd_front #(
    parameter int LINE_COUNT = mcd_pkg::DEF_LINE_COUNT
) (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,
    input  wire logic [2:0]                    s_tuser,
    input  wire logic                          clearing,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [$clog2(LINE_COUNT)-1:0]      q_line,
    output mcd_pkg::req_t                      q_req
);
    import mcd_pkg::*;

    localparam int LINE_BITS = $clog2(LINE_COUNT);

    logic [9:0] line_red;

    assign s_tready = !clearing && !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Unpack the beat into a request record.
    always_comb begin
        q_req.act   = act_t'(s_tuser);
        q_req.hart  = s_tdata[2:0];
        q_req.trunk = s_tdata[13];
        q_req.src   = s_tdata[21:14];
        q_req.size  = s_tdata[25:22];
        q_req.keeps = s_tdata[26];
        q_req.ack   = s_tdata[30:27];
    end

    // Reduce the line number modulo the directory size by binary compare and subtract.
    always_comb begin
        line_red = s_tdata[12:3];
        for (int k = 9; k >= 0; k--) begin
            if ((LINE_COUNT << k) <= 1023) begin
                if (32'(line_red) >= (LINE_COUNT << k)) begin
                    line_red = line_red - 10'(LINE_COUNT << k);
                end
            end
        end
        q_line = LINE_BITS'(line_red);
    end

endmodule
`default_nettype wire

// File: rtl/core/mcd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mcd_back #(
    parameter int HART_COUNT = mcd_pkg::DEF_HART_COUNT,
    parameter int LINE_COUNT = mcd_pkg::DEF_LINE_COUNT,
    parameter int SINK_BITS  = mcd_pkg::DEF_SINK_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [3:0]                    cfg_wdata,
    input  wire logic                          q_valid,
    input  wire logic [$clog2(LINE_COUNT)-1:0] q_line,
    input  mcd_pkg::req_t                      q_req,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output mcd_pkg::kind_t                     m_kind,
    output logic                               m_last,
    output logic [2:0]                         m_target,
    output logic [1:0]                         m_cap,
    output logic [7:0]                         m_src,
    output logic [3:0]                         m_size,
    output logic [3:0]                         m_sink,
    output logic                               m_exh,
    output mcd_pkg::back_stat_t                stat
);
    import mcd_pkg::*;

    localparam int LINE_BITS = $clog2(LINE_COUNT);
    localparam int MW        = (HART_COUNT > 8) ? HART_COUNT : 8;
    localparam int HW        = $clog2(MW);
    localparam int EW        = 2 + MW + 1 + 3;
    localparam int SINK_IDS  = 1 << SINK_BITS;

    bstate_t              state_reg, state_next;
    req_t                 cur_reg, cur_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] clr_reg, clr_next;
    logic [3:0]           active_reg, active_next;
    logic [MW-1:0]        pmask_reg, pmask_next;
    logic [1:0]           pcap_reg, pcap_next;
    logic [HW-1:0]        h_reg, h_next;
    kind_t                rkind_reg, rkind_next;
    logic [1:0]           rcap_reg, rcap_next;
    logic                 rneed_reg, rneed_next;
    logic                 rhas_reg, rhas_next;
    logic [SINK_BITS-1:0] scnt_reg, scnt_next;
    logic [SINK_IDS-1:0]  pend_reg, pend_next;
    logic [SINK_BITS-1:0] walk_reg, walk_next;
    logic [SINK_BITS-1:0] rsink_reg, rsink_next;
    logic                 rexh_reg, rexh_next;
    logic                 mv_reg, mv_next;
    kind_t                mkind_reg, mkind_next;
    logic                 mlast_reg, mlast_next;
    logic [2:0]           mtgt_reg, mtgt_next;
    logic [1:0]           mcap_reg, mcap_next;
    logic [7:0]           msrc_reg, msrc_next;
    logic [3:0]           msize_reg, msize_next;
    logic [3:0]           msink_reg, msink_next;
    logic                 mexh_reg, mexh_next;

    logic                 ram_we;
    logic [LINE_BITS-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, ram_rdata;

    // Directory entry fields and the planned update.
    logic [1:0]    rd_st, n_st;
    logic [MW-1:0] rd_mask, n_mask;
    logic          rd_ov, n_ov;
    logic [2:0]    rd_oid, n_oid;
    logic [MW-1:0] pm;
    logic [1:0]    pc;
    kind_t         rk;
    logic [1:0]    rc;
    logic          ns, hr;
    logic [5:0]    present;
    logic [MW-1:0] pres_mask, hbit, req_bit;
    logic          hit, trunk_st, out_free, probe_done, sink_found;
    logic [SINK_BITS-1:0] cand;
    logic [SINK_BITS-1:0] ack_id;

    mcd_ram #(
        .WIDTH (EW),
        .DEPTH (LINE_COUNT)
    ) u_dir (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {rd_oid, rd_ov, rd_mask, rd_st} = ram_rdata;

    // Harts present and per-item helper terms.
    always_comb begin
        present = (32'(active_reg) < HART_COUNT) ? 6'(active_reg) : 6'(HART_COUNT);
        for (int h = 0; h < MW; h++) begin
            pres_mask[h] = (6'(h) < present);
        end
        req_bit  = MW'(1) << cur_reg.hart;
        hbit     = MW'(1) << h_reg;
        hit      = (rd_st != LS_I) && (rd_mask != '0);
        trunk_st = (rd_st == LS_E) || (rd_st == LS_M);
        out_free = !mv_reg || m_ready;
        probe_done = ((pmask_reg & ~hbit) == '0) && (!pmask_reg[h_reg] || out_free);
        cand     = scnt_reg + walk_reg;
        sink_found = (cand != '0) && !pend_reg[cand];
        ack_id   = SINK_BITS'(cur_reg.ack);
    end

    // Directory decision for the request under way.
    always_comb begin
        n_st   = rd_st;
        n_mask = rd_mask;
        n_ov   = rd_ov;
        n_oid  = rd_oid;
        pm     = '0;
        pc     = CAP_N;
        rk     = KIND_GRANT_DATA;
        rc     = CAP_T;
        ns     = 1'b0;
        hr     = 1'b0;
        case (cur_reg.act)
            ACT_ACQ_BLOCK: begin
                hr = 1'b1;
                ns = 1'b1;
                rk = KIND_GRANT_DATA;
                rc = cur_reg.trunk ? CAP_T : CAP_B;
                if (hit) begin
                    if (trunk_st && rd_ov && (rd_oid != cur_reg.hart || !cur_reg.trunk)) begin
                        pm = (MW'(1) << rd_oid) & pres_mask;
                        pc = cur_reg.trunk ? CAP_N : CAP_B;
                        if (!cur_reg.trunk) begin
                            n_st   = LS_S;
                            n_mask = rd_mask | req_bit;
                            n_ov   = 1'b0;
                            n_oid  = '0;
                        end else begin
                            n_st   = LS_E;
                            n_mask = req_bit;
                            n_ov   = 1'b1;
                            n_oid  = cur_reg.hart;
                        end
                    end else if (rd_st == LS_S && cur_reg.trunk) begin
                        pm     = rd_mask & ~req_bit & pres_mask;
                        n_st   = LS_E;
                        n_mask = req_bit;
                        n_ov   = 1'b1;
                        n_oid  = cur_reg.hart;
                    end else if (rd_st == LS_S) begin
                        n_mask = rd_mask | req_bit;
                    end
                end else begin
                    rc     = CAP_T;
                    n_st   = LS_E;
                    n_mask = req_bit;
                    n_ov   = 1'b1;
                    n_oid  = cur_reg.hart;
                end
            end
            ACT_ACQ_PERM: begin
                hr = 1'b1;
                ns = 1'b1;
                rk = KIND_GRANT;
                if (hit) begin
                    pm = rd_mask & ~req_bit & pres_mask;
                end
                n_st   = LS_E;
                n_mask = req_bit;
                n_ov   = 1'b1;
                n_oid  = cur_reg.hart;
            end
            ACT_RELEASE, ACT_RELEASE_D: begin
                hr = 1'b1;
                rk = KIND_REL_ACK;
                rc = CAP_T;
                if (hit) begin
                    n_mask = rd_mask & ~req_bit;
                    if (cur_reg.keeps && (6'(cur_reg.hart) < present)) begin
                        n_mask = n_mask | req_bit;
                    end
                    n_ov  = 1'b0;
                    n_oid = '0;
                    n_st  = (n_mask == '0) ? LS_I : LS_S;
                end
            end
            ACT_MARK_MOD: begin
                if (hit && rd_ov && rd_oid == cur_reg.hart && trunk_st) begin
                    n_st = LS_M;
                end
            end
            ACT_GRANT_ACK: begin
                n_st = rd_st;
            end
            ACT_INV_OTHERS: begin
                pm     = pres_mask & ~req_bit;
                n_st   = LS_I;
                n_mask = '0;
                n_ov   = 1'b0;
                n_oid  = '0;
            end
            default: begin
                pm     = pres_mask;
                n_st   = LS_I;
                n_mask = '0;
                n_ov   = 1'b0;
                n_oid  = '0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BS_CLEAR: begin
                if (clr_reg == LINE_BITS'(LINE_COUNT - 1)) begin
                    state_next = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (q_valid) begin
                    state_next = BS_READ;
                end
            end
            BS_READ: begin
                if (pm != '0) begin
                    state_next = BS_PROBE;
                end else if (hr) begin
                    state_next = ns ? BS_SINK : BS_REPLY;
                end else begin
                    state_next = BS_IDLE;
                end
            end
            BS_PROBE: begin
                if (probe_done) begin
                    if (rhas_reg) begin
                        state_next = rneed_reg ? BS_SINK : BS_REPLY;
                    end else begin
                        state_next = BS_IDLE;
                    end
                end
            end
            BS_SINK: begin
                if (sink_found || walk_reg == '1) begin
                    state_next = BS_REPLY;
                end
            end
            BS_REPLY: begin
                if (out_free) begin
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // Datapath and result beats for each state.
    always_comb begin
        cur_next   = cur_reg;
        line_next  = line_reg;
        clr_next   = clr_reg;
        pmask_next = pmask_reg;
        pcap_next  = pcap_reg;
        h_next     = h_reg;
        rkind_next = rkind_reg;
        rcap_next  = rcap_reg;
        rneed_next = rneed_reg;
        rhas_next  = rhas_reg;
        scnt_next  = scnt_reg;
        pend_next  = pend_reg;
        walk_next  = walk_reg;
        rsink_next = rsink_reg;
        rexh_next  = rexh_reg;
        mv_next    = mv_reg && !m_ready;
        mkind_next = mkind_reg;
        mlast_next = mlast_reg;
        mtgt_next  = mtgt_reg;
        mcap_next  = mcap_reg;
        msrc_next  = msrc_reg;
        msize_next = msize_reg;
        msink_next = msink_reg;
        mexh_next  = mexh_reg;
        ram_we     = 1'b0;
        ram_waddr  = line_reg;
        ram_wdata  = {n_oid, n_ov, n_mask, n_st};
        ram_raddr  = q_line;
        q_pop      = 1'b0;
        active_next = cfg_we ? cfg_wdata : active_reg;
        case (state_reg)
            BS_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            BS_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    cur_next  = q_req;
                    line_next = q_line;
                end
            end
            BS_READ: begin
                ram_we     = 1'b1;
                pmask_next = pm;
                pcap_next  = pc;
                h_next     = '0;
                rkind_next = rk;
                rcap_next  = rc;
                rneed_next = ns;
                rhas_next  = hr;
                walk_next  = '0;
                rsink_next = '0;
                rexh_next  = 1'b0;
                if (cur_reg.act == ACT_GRANT_ACK) begin
                    pend_next[ack_id] = 1'b0;
                end
            end
            BS_PROBE: begin
                if (pmask_reg[h_reg]) begin
                    if (out_free) begin
                        mv_next    = 1'b1;
                        mkind_next = KIND_PROBE;
                        mlast_next = !rhas_reg && ((pmask_reg & ~hbit) == '0);
                        mtgt_next  = 3'(h_reg);
                        mcap_next  = pcap_reg;
                        msrc_next  = '0;
                        msize_next = '0;
                        msink_next = '0;
                        mexh_next  = 1'b0;
                        pmask_next = pmask_reg & ~hbit;
                        h_next     = h_reg + 1'b1;
                    end
                end else begin
                    h_next = h_reg + 1'b1;
                end
            end
            BS_SINK: begin
                if (sink_found) begin
                    pend_next[cand] = 1'b1;
                    scnt_next  = cand + 1'b1;
                    rsink_next = cand;
                    rexh_next  = 1'b0;
                end else if (walk_reg == '1) begin
                    rsink_next = '0;
                    rexh_next  = 1'b1;
                end else begin
                    walk_next = walk_reg + 1'b1;
                end
            end
            BS_REPLY: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mkind_next = rkind_reg;
                    mlast_next = 1'b1;
                    mtgt_next  = '0;
                    mcap_next  = rcap_reg;
                    msrc_next  = cur_reg.src;
                    msize_next = cur_reg.size;
                    msink_next = 4'(rsink_reg);
                    mexh_next  = rexh_reg;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BS_CLEAR;
            clr_reg    <= '0;
            active_reg <= 4'd8;
            scnt_reg   <= '0;
            pend_reg   <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            active_reg <= active_next;
            scnt_reg   <= scnt_next;
            pend_reg   <= pend_next;
            mv_reg     <= mv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        line_reg  <= line_next;
        pmask_reg <= pmask_next;
        pcap_reg  <= pcap_next;
        h_reg     <= h_next;
        rkind_reg <= rkind_next;
        rcap_reg  <= rcap_next;
        rneed_reg <= rneed_next;
        rhas_reg  <= rhas_next;
        walk_reg  <= walk_next;
        rsink_reg <= rsink_next;
        rexh_reg  <= rexh_next;
        mkind_reg <= mkind_next;
        mlast_reg <= mlast_next;
        mtgt_reg  <= mtgt_next;
        mcap_reg  <= mcap_next;
        msrc_reg  <= msrc_next;
        msize_reg <= msize_next;
        msink_reg <= msink_next;
        mexh_reg  <= mexh_next;
    end

    assign m_valid  = mv_reg;
    assign m_kind   = mkind_reg;
    assign m_last   = mlast_reg;
    assign m_target = mtgt_reg;
    assign m_cap    = mcap_reg;
    assign m_src    = msrc_reg;
    assign m_size   = msize_reg;
    assign m_sink   = msink_reg;
    assign m_exh    = mexh_reg;

    // Status: sweep in progress, then the sink zero pending bit.
    assign stat = {(state_reg == BS_CLEAR), pend_reg[0]};

endmodule
`default_nettype wire

// File: rtl/core/mesi_coherence_directory.sv
`timescale 1ns / 1ps
`default_nettype none
// Full-map MESI directory. After reset the block sweeps its LINE_COUNT-entry directory memory,
// one entry a cycle, and takes no request until that is done. A request then passes through
// a two-entry queue to the back end, which reads the entry, walks the hart positions one a
// cycle (waiting at a probe while the output is stalled) up to the last hart it probes,
// searches for a free sink id one candidate a cycle for grants, and then issues the grant
// or release ack. Results leave through an output register, and the front keeps queueing
// requests while the queue has room.
module mesi_coherence_directory #(
    parameter int HART_COUNT = mcd_pkg::DEF_HART_COUNT,
    parameter int LINE_COUNT = mcd_pkg::DEF_LINE_COUNT,
    parameter int SINK_BITS  = mcd_pkg::DEF_SINK_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,  // active_harts
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // requester_hart, line_index, want_trunk, source_id, transfer_size,
    // still_holds_copy, ack_sink, zero pad
    input  wire logic [31:0] s_tdata,
    input  wire logic [2:0]  s_tuser,    // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // target_hart, cap, reply_source, reply_size, grant_sink, sink_exhausted, zero pad
    output logic [23:0]      m_tdata,
    output logic [1:0]       m_tuser,    // kind
    output logic             m_tlast     // last_of_run
);
    import mcd_pkg::*;

    `include "mesi_coherence_directory_assert.svh"

    localparam int LINE_BITS = $clog2(LINE_COUNT);
    localparam int QW        = LINE_BITS + $bits(req_t);

    back_stat_t           bstat;
    logic                 f_push, q_full, q_valid, q_pop;
    logic [LINE_BITS-1:0] f_line, b_line;
    req_t                 f_req, b_req;
    logic [QW-1:0]        q_out;
    kind_t                o_kind;
    logic [2:0]           o_tgt;
    logic [1:0]           o_cap;
    logic [7:0]           o_src;
    logic [3:0]           o_size, o_sink;
    logic                 o_exh;

    mcd_front #(
        .LINE_COUNT (LINE_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (bstat.clearing),
        .q_full   (q_full),
        .q_push   (f_push),
        .q_line   (f_line),
        .q_req    (f_req)
    );

    mcd_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_line, f_req}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    assign {b_line, b_req} = q_out;

    mcd_back #(
        .HART_COUNT (HART_COUNT),
        .LINE_COUNT (LINE_COUNT),
        .SINK_BITS  (SINK_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_line    (b_line),
        .q_req     (b_req),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_kind    (o_kind),
        .m_last    (m_tlast),
        .m_target  (o_tgt),
        .m_cap     (o_cap),
        .m_src     (o_src),
        .m_size    (o_size),
        .m_sink    (o_sink),
        .m_exh     (o_exh),
        .stat      (bstat)
    );

    // Pack the result beat.
    assign m_tuser = o_kind;
    assign m_tdata = {2'b00, o_exh, o_sink, o_size, o_src, o_cap, o_tgt};

    `MCD_ASSERT_IMPLY(a_no_accept_in_clear, aclk, aresetn, bstat.clearing, !s_tready, "request taken during directory sweep")
    `MCD_ASSERT_ALWAYS(a_sink_zero_free, aclk, aresetn, !bstat.sink0_pending, "sink id zero marked pending")
    `MCD_ASSERT_IMPLY(a_exh_on_grant, aclk, aresetn, m_tvalid && m_tdata[21], (m_tuser == 2'(KIND_GRANT) || m_tuser == 2'(KIND_GRANT_DATA)) && m_tlast, "exhausted flag off a grant")
    `MCD_ASSERT_IMPLY(a_probe_clean, aclk, aresetn, m_tvalid && m_tuser == 2'(KIND_PROBE), m_tdata[21:5] == 17'd0, "probe carries reply fields")

endmodule
`default_nettype wire
